@@ rtl/scwp_pkg.sv @@
// Shared types and constants for the Schulze widest-path strength core.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package scwp_pkg;

    localparam int CC_W       = 5;
    localparam int INDEX_W    = 4;
    localparam int STRENGTH_W = 16;

    localparam logic [CC_W-1:0] CC_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } opcode_e;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic item_load;
        logic cnt_wr;
        logic clr_wr;
        logic a_clr;
        logic a_inc;
        logic b_clr;
        logic b_inc;
        logic m_clr;
        logic m_inc;
        logic rd_item;
        logic init_rd;
        logic init_wr;
        logic via_rd;
        logic via_latch;
        logic fw_rd;
        logic fw_wr;
        logic res_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        opcode_e op;
        logic    n_zero;
        logic    clr_last;
        logic    a_last;
        logic    b_last;
        logic    m_last;
        logic    a_is_m;
    } sts_t;

endpackage

@@ rtl/scwp_if.sv @@
// Valid/ready channel interfaces: request items, result items, config writes.
// Depends on scwp_pkg for field widths.
interface scwp_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic [scwp_pkg::INDEX_W-1:0]        row_index;
    logic [scwp_pkg::INDEX_W-1:0]        col_index;
    logic [scwp_pkg::STRENGTH_W-1:0]     pair_count;

    modport source (output valid, output opcode, output row_index, output col_index,
                    output pair_count, input ready);
    modport sink   (input valid, input opcode, input row_index, input col_index,
                    input pair_count, output ready);
endinterface

interface scwp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [scwp_pkg::STRENGTH_W-1:0]     path_strength;
    logic                                status;

    modport source (output valid, output path_strength, output status, input ready);
    modport sink   (input valid, input path_strength, input status, output ready);
endinterface

interface scwp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [scwp_pkg::CC_W-1:0]           candidate_count;

    modport source (output valid, output candidate_count, input ready);
    modport sink   (input valid, input candidate_count, output ready);
endinterface

@@ rtl/scwp_ctrl.sv @@
// Sequencer for the strength core: clearing pass, load/read/compute flow,
// result handshake. Depends on scwp_pkg; drives the datapath by cmd_t.
module scwp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  scwp_pkg::sts_t sts,
    output scwp_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ISSUE,
        S_RESULT,
        S_INIT_RD,
        S_INIT_WR,
        S_FW_HEAD,
        S_FW_LATCH,
        S_FW_RD,
        S_FW_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    case (sts.op)
                        scwp_pkg::OP_LOAD:
                        begin
                            cmd.cnt_wr = 1'b1;
                        end
                        scwp_pkg::OP_COMPUTE:
                        begin
                            cmd.a_clr  = 1'b1;
                            cmd.b_clr  = 1'b1;
                            cmd.m_clr  = 1'b1;
                            state_next = sts.n_zero ? S_RESULT : S_INIT_RD;
                        end
                        scwp_pkg::OP_READ:
                        begin
                            state_next = S_RD_ISSUE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_item = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_INIT_RD:
            begin
                cmd.init_rd = 1'b1;
                state_next  = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                cmd.init_wr = 1'b1;
                state_next  = S_INIT_RD;
                if (sts.b_last)
                begin
                    cmd.b_clr = 1'b1;
                    if (sts.a_last)
                    begin
                        cmd.a_clr  = 1'b1;
                        state_next = S_FW_HEAD;
                    end
                    else
                    begin
                        cmd.a_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.b_inc = 1'b1;
                end
            end
            S_FW_HEAD:
            begin
                if (sts.a_is_m)
                begin
                    // skip the intermediate's own row
                    state_next = S_FW_HEAD;
                    if (sts.a_last)
                    begin
                        if (sts.m_last)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.m_inc = 1'b1;
                            cmd.a_clr = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.a_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.via_rd = 1'b1;
                    cmd.b_clr  = 1'b1;
                    state_next = S_FW_LATCH;
                end
            end
            S_FW_LATCH:
            begin
                cmd.via_latch = 1'b1;
                state_next    = S_FW_RD;
            end
            S_FW_RD:
            begin
                cmd.fw_rd  = 1'b1;
                state_next = S_FW_WR;
            end
            S_FW_WR:
            begin
                cmd.fw_wr = 1'b1;
                if (sts.b_last)
                begin
                    state_next = S_FW_HEAD;
                    if (sts.a_last)
                    begin
                        if (sts.m_last)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.m_inc = 1'b1;
                            cmd.a_clr = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.a_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.b_inc  = 1'b1;
                    state_next = S_FW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/scwp_datapath.sv @@
// Count and strength memories, loop counters, item and result registers.
// Depends on scwp_pkg; sequenced by scwp_ctrl through cmd_t / sts_t.
module scwp_datapath #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scwp_pkg::cmd_t                    cmd,
    output scwp_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [scwp_pkg::CC_W-1:0]         cfg_data,
    input  logic [1:0]                        req_opcode,
    input  logic [scwp_pkg::INDEX_W-1:0]      req_row,
    input  logic [scwp_pkg::INDEX_W-1:0]      req_col,
    input  logic [scwp_pkg::STRENGTH_W-1:0]   req_count,
    output logic [scwp_pkg::STRENGTH_W-1:0]   path_strength,
    output logic                              status
);

    localparam int IDXW  = $clog2(MAX_CANDIDATES);
    localparam int ADDRW = 2 * IDXW;
    localparam int DEPTH = 1 << ADDRW;
    localparam int NW    = $clog2(MAX_CANDIDATES + 1);
    localparam int CMPW  = (NW > scwp_pkg::CC_W) ? NW : scwp_pkg::CC_W;
    localparam int SW    = scwp_pkg::STRENGTH_W;

    logic [SW-1:0] count_mem    [DEPTH];
    logic [SW-1:0] strength_mem [DEPTH];

    logic [scwp_pkg::CC_W-1:0] cc_reg;
    logic [CMPW-1:0]           n_val;
    logic [CMPW-1:0]           cc_ext;
    logic                      req_ok;

    scwp_pkg::opcode_e op_reg;
    logic [IDXW-1:0]   row_reg;
    logic [IDXW-1:0]   col_reg;
    logic              ok_reg;

    logic [IDXW-1:0]   a_reg;
    logic [IDXW-1:0]   b_reg;
    logic [IDXW-1:0]   m_reg;
    logic [ADDRW-1:0]  clr_reg;

    logic [SW-1:0]     sa_reg;
    logic [SW-1:0]     sb_reg;
    logic [SW-1:0]     ca_reg;
    logic [SW-1:0]     cb_reg;
    logic [SW-1:0]     via_reg;
    logic [SW-1:0]     res_strength_reg;
    logic              res_status_reg;

    logic [ADDRW-1:0]  rda_addr;
    logic              rda_en;
    logic [ADDRW-1:0]  wr_addr;
    logic [SW-1:0]     wr_data;
    logic              wr_en;
    logic [SW-1:0]     init_val;
    logic [SW-1:0]     via_min;
    logic              fw_update;

    // Effective candidate count: saturate to the matrix size
    assign cc_ext = CMPW'(cc_reg);
    assign n_val  = (cc_ext > CMPW'(MAX_CANDIDATES)) ? CMPW'(MAX_CANDIDATES) : cc_ext;
    assign req_ok = (CMPW'(req_row) < n_val) && (CMPW'(req_col) < n_val);

    assign sts.op       = scwp_pkg::opcode_e'(req_opcode);
    assign sts.n_zero   = (n_val == '0);
    assign sts.clr_last = &clr_reg;
    assign sts.a_last   = (CMPW'(a_reg) == n_val - CMPW'(1));
    assign sts.b_last   = (CMPW'(b_reg) == n_val - CMPW'(1));
    assign sts.m_last   = (CMPW'(m_reg) == n_val - CMPW'(1));
    assign sts.a_is_m   = (a_reg == m_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= scwp_pkg::CC_RESET;
            op_reg  <= scwp_pkg::OP_NOP;
            a_reg   <= '0;
            b_reg   <= '0;
            m_reg   <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cc_reg <= cfg_data;
            end
            if (cmd.item_load)
            begin
                op_reg <= scwp_pkg::opcode_e'(req_opcode);
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + ADDRW'(1);
            end
            if (cmd.a_clr)
            begin
                a_reg <= '0;
            end
            else if (cmd.a_inc)
            begin
                a_reg <= a_reg + IDXW'(1);
            end
            if (cmd.b_clr)
            begin
                b_reg <= '0;
            end
            else if (cmd.b_inc)
            begin
                b_reg <= b_reg + IDXW'(1);
            end
            if (cmd.m_clr)
            begin
                m_reg <= '0;
            end
            else if (cmd.m_inc)
            begin
                m_reg <= m_reg + IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            row_reg <= IDXW'(req_row);
            col_reg <= IDXW'(req_col);
            ok_reg  <= req_ok;
        end
        if (cmd.via_latch)
        begin
            via_reg <= sa_reg;
        end
        if (cmd.res_load)
        begin
            if (op_reg == scwp_pkg::OP_READ)
            begin
                res_strength_reg <= ok_reg ? sa_reg : '0;
                res_status_reg   <= !ok_reg;
            end
            else
            begin
                res_strength_reg <= '0;
                res_status_reg   <= 1'b0;
            end
        end
    end

    assign path_strength = res_strength_reg;
    assign status        = res_status_reg;

    // Count memory: written by loads, read as forward/reverse pair at init
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_wr && req_ok)
        begin
            count_mem[{IDXW'(req_row), IDXW'(req_col)}] <= req_count;
        end
        if (cmd.init_rd)
        begin
            ca_reg <= count_mem[{a_reg, b_reg}];
            cb_reg <= count_mem[{b_reg, a_reg}];
        end
    end

    // Strength memory port A: item read, via link read, row-m read
    always_comb
    begin
        rda_en   = cmd.rd_item || cmd.via_rd || cmd.fw_rd;
        rda_addr = {m_reg, b_reg};
        if (cmd.rd_item)
        begin
            rda_addr = {row_reg, col_reg};
        end
        else if (cmd.via_rd)
        begin
            rda_addr = {a_reg, m_reg};
        end
    end

    assign init_val  = ((a_reg != b_reg) && (ca_reg > cb_reg)) ? ca_reg : '0;
    assign via_min   = (sa_reg < via_reg) ? sa_reg : via_reg;
    assign fw_update = (b_reg != m_reg) && (b_reg != a_reg) && (via_min > sb_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {a_reg, b_reg};
        wr_data = via_min;
        if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.init_wr)
        begin
            wr_en   = 1'b1;
            wr_data = init_val;
        end
        else if (cmd.fw_wr)
        begin
            wr_en = fw_update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            strength_mem[wr_addr] <= wr_data;
        end
        if (rda_en)
        begin
            sa_reg <= strength_mem[rda_addr];
        end
        if (cmd.fw_rd)
        begin
            sb_reg <= strength_mem[{a_reg, b_reg}];
        end
    end

endmodule

@@ rtl/schulze_widest_path_strengths_core.sv @@
// Top level of the Schulze widest-path strength core.
// Depends on scwp_pkg, scwp_if, scwp_ctrl and scwp_datapath.
//
//   channel  dir  payload                                        beat taken when
//   req      in   opcode, row_index, col_index, pair_count      req.valid & req.ready
//   rsp      out  path_strength, status                         rsp.valid & rsp.ready
//   cfg      in   candidate_count                               cfg.valid & cfg.ready
//
// Load and opcode 3 are taken in S_IDLE with no result; a read passes through
// S_RD_ISSUE and S_RESULT. Compute runs on one shared min-max unit over one
// strength memory: an init pass over all pairs, then a relaxation per intermediate.
// After reset a clearing pass writes zero to every strength entry, one per
// cycle (256 entries at 16 candidates); req is not ready until it ends.
// A waiting result is held in the output register while loads keep flowing.
module schulze_widest_path_strengths_core #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    scwp_req_if.sink req,
    scwp_rsp_if.source rsp,
    scwp_cfg_if.sink cfg
);

    scwp_pkg::cmd_t cmd;
    scwp_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    scwp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scwp_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.candidate_count),
        .req_opcode    (req.opcode),
        .req_row       (req.row_index),
        .req_col       (req.col_index),
        .req_count     (req.pair_count),
        .path_strength (rsp.path_strength),
        .status        (rsp.status)
    );

endmodule
